### rtl/assert_macros.svh
// Assertion macros used by the sort engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expr must hold at every clock edge outside reset
`define KSE_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("kse assertion failed");
// when trig holds, cons must hold in the following cycle
`define KSE_ASSERT_NEXT(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("kse assertion failed");
`else
`define KSE_ASSERT_ALWAYS(lbl, expr)
`define KSE_ASSERT_NEXT(lbl, trig, cons)
`endif
`endif

### rtl/kse_pkg.sv
// Shared constants and types of the key sort engine.
package kse_pkg;

	localparam int unsigned CAPACITY_DEF = 64;
	localparam int unsigned KEY_BITS_DEF = 32;
	localparam int unsigned KEY_FIELD_W  = 32;

	// what every cell of the chain does in a cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT,
		CELL_ROTATE
	} cell_op_t;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		cell_op_t op;
		logic     load_key;
	} cell_ctl_t;

endpackage

### rtl/kse_cell.sv
// One cell of the insertion chain: a key, its valid bit, and a comparator.
module kse_cell #(
	parameter int unsigned KEY_BITS = kse_pkg::KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kse_pkg::cell_ctl_t  ctl,
	input  logic [KEY_BITS-1:0] new_key,
	input  logic [KEY_BITS-1:0] prev_key,
	input  logic                prev_valid,
	input  logic                prev_after,
	input  logic [KEY_BITS-1:0] next_key,
	input  logic                next_valid,
	input  logic [KEY_BITS-1:0] head_key,
	input  logic                is_tail,
	output logic [KEY_BITS-1:0] key,
	output logic                valid,
	output logic                after
);
	import kse_pkg::*;

	logic [KEY_BITS-1:0] key_q;
	logic                valid_q;
	logic [KEY_BITS-1:0] key_d;
	logic                valid_d;

	// stored key orders after the incoming one (unsigned order)
	assign after = valid_q && (key_q > new_key);

	always_comb begin
		key_d   = key_q;
		valid_d = valid_q;
		case (ctl.op)
			CELL_INSERT: begin
				if (ctl.load_key) begin
					if (prev_after) begin
						key_d   = prev_key;
						valid_d = 1'b1;
					end else if (after || (!valid_q && prev_valid)) begin
						key_d   = new_key;
						valid_d = 1'b1;
					end
				end
			end
			CELL_SHIFT: begin
				key_d   = next_key;
				valid_d = next_valid;
			end
			CELL_ROTATE: begin
				if (valid_q) begin
					key_d = is_tail ? head_key : next_key;
				end
			end
			default: begin
				key_d   = key_q;
				valid_d = valid_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

	assign key   = key_q;
	assign valid = valid_q;

endmodule

### rtl/key_sort_engine_unit.sv
// Top level of the key sort engine: sequencer, insertion chain, output register.
//
//  channel  | payload                               | handshake
//  ---------+---------------------------------------+----------------------
//  input    | key_value, is_last                    | in_valid / in_stall
//  output   | sorted_key, end_of_list, overflowed   | out_valid / out_stall
//  config   | cfg_wr_data (compare_mode)            | cfg_wr_en
//
// Loading takes one key per cycle while in_stall is low; a key that finds room
// is inserted in the cycle of its transfer, a key past capacity is dropped.
// After the last key, signed mode rotates the non-negative run to the tail;
// emission then moves one key per cycle out of cell 0 when the output register
// can take it. in_stall is high from the last key until the final result is
// loaded into the output register. Reset clears all but keys and output data.
`include "assert_macros.svh"

module key_sort_engine_unit #(
	parameter int unsigned CAPACITY = kse_pkg::CAPACITY_DEF,
	parameter int unsigned KEY_BITS = kse_pkg::KEY_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_wr_en,
	input  logic                               cfg_wr_data,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [kse_pkg::KEY_FIELD_W-1:0]    key_value,
	input  logic                               is_last,
	// output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [kse_pkg::KEY_FIELD_W-1:0]    sorted_key,
	output logic                               end_of_list,
	output logic                               overflowed
);
	import kse_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROTATE,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic             mode_q;       // compare_mode register
	logic [CNT_W-1:0] count_q;      // keys held in the chain
	logic [CNT_W-1:0] left_q;       // keys still to emit
	logic [CNT_W-1:0] rot_q;        // keys rotated so far
	logic             ovf_q;

	logic                out_valid_q;
	logic [KEY_FIELD_W-1:0] out_key_q;
	logic                out_eol_q;
	logic                out_ovf_q;

	logic [KEY_BITS-1:0] new_key;
	logic [KEY_BITS-1:0] cell_key [CAPACITY];
	logic [CAPACITY-1:0] cell_valid;
	logic [CAPACITY-1:0] cell_after;
	logic [CAPACITY-1:0] tail_vec;
	logic [KEY_FIELD_W-1:0] head_out;

	logic      in_xfer;
	logic      has_room;
	logic      emit_load;
	logic      rot_done;
	cell_ctl_t ctl;

	// ---------------------------------------------------------------
	// Field width adaptation between the 32-bit ports and KEY_BITS keys
	// ---------------------------------------------------------------
	generate
		if (KEY_BITS >= KEY_FIELD_W) begin : g_wide
			assign new_key  = KEY_BITS'(key_value);
			assign head_out = cell_key[0][KEY_FIELD_W-1:0];
		end else begin : g_narrow
			assign new_key  = key_value[KEY_BITS-1:0];
			assign head_out = KEY_FIELD_W'(cell_key[0]);
		end
	endgenerate

	// ---------------------------------------------------------------
	// Handshake and sequencing conditions
	// ---------------------------------------------------------------
	assign in_stall  = (state_q != ST_LOAD);
	assign in_xfer   = in_valid && !in_stall;
	assign has_room  = (count_q < CAP_CNT);
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	// signed order: stop once the head holds a negative key or all went round
	assign rot_done  = (rot_q == count_q) || cell_key[0][KEY_BITS-1];

	always_comb begin
		ctl.op       = CELL_HOLD;
		ctl.load_key = 1'b0;
		case (state_q)
			ST_LOAD: begin
				ctl.op       = CELL_INSERT;
				ctl.load_key = in_xfer && has_room;
			end
			ST_ROTATE: begin
				if (!rot_done) begin
					ctl.op = CELL_ROTATE;
				end
			end
			ST_EMIT: begin
				if (emit_load) begin
					ctl.op = CELL_SHIFT;
				end
			end
			default: begin
				ctl.op = CELL_HOLD;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// The chain: cell 0 is the smallest key and the emission point
	// ---------------------------------------------------------------
	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic [KEY_BITS-1:0] p_key;
			logic                p_valid;
			logic                p_after;
			logic [KEY_BITS-1:0] n_key;
			logic                n_valid;

			assign tail_vec[i] = (count_q == CNT_W'(i + 1));

			if (i == 0) begin : g_first
				assign p_key   = new_key;
				assign p_valid = 1'b1;
				assign p_after = 1'b0;
			end else begin : g_mid
				assign p_key   = cell_key[i-1];
				assign p_valid = cell_valid[i-1];
				assign p_after = cell_after[i-1];
			end

			if (i == CAPACITY - 1) begin : g_last
				assign n_key   = cell_key[i];
				assign n_valid = 1'b0;
			end else begin : g_inner
				assign n_key   = cell_key[i+1];
				assign n_valid = cell_valid[i+1];
			end

			kse_cell #(
				.KEY_BITS (KEY_BITS)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.new_key    (new_key),
				.prev_key   (p_key),
				.prev_valid (p_valid),
				.prev_after (p_after),
				.next_key   (n_key),
				.next_valid (n_valid),
				.head_key   (cell_key[0]),
				.is_tail    (tail_vec[i]),
				.key        (cell_key[i]),
				.valid      (cell_valid[i]),
				.after      (cell_after[i])
			);
		end
	endgenerate

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			mode_q  <= 1'b0;
			count_q <= '0;
			left_q  <= '0;
			rot_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (has_room) begin
							count_q <= count_q + 1'b1;
							left_q  <= count_q + 1'b1;
						end else begin
							ovf_q  <= 1'b1;
							left_q <= count_q;
						end
						if (is_last) begin
							rot_q   <= '0;
							state_q <= mode_q ? ST_ROTATE : ST_EMIT;
						end
					end
				end
				ST_ROTATE: begin
					if (rot_done) begin
						state_q <= ST_EMIT;
					end else begin
						rot_q <= rot_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						left_q <= left_q - 1'b1;
						if (left_q == CNT_W'(1)) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Output register: lets loading of the next list overlap the last transfer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_key_q <= head_out;
			out_eol_q <= (left_q == CNT_W'(1));
			out_ovf_q <= ovf_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign sorted_key  = out_key_q;
	assign end_of_list = out_eol_q;
	assign overflowed  = out_ovf_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`KSE_ASSERT_ALWAYS(a_count_bound, count_q <= CAP_CNT)
	`KSE_ASSERT_ALWAYS(a_valid_packed, (cell_valid & (cell_valid + 1'b1)) == '0)
	`KSE_ASSERT_ALWAYS(a_fill_matches, (state_q != ST_LOAD) || ($countones(cell_valid) == 32'(count_q)))
	`KSE_ASSERT_NEXT(a_list_done, emit_load && (left_q == CNT_W'(1)), (state_q == ST_LOAD) && (cell_valid == '0))

endmodule

### sim/key_sort_engine_unit_tb.sv
// Self-checking testbench for key_sort_engine_unit: directed table, random lists, sort predictor.
module key_sort_engine_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = kse_pkg::CAPACITY_DEF;
	localparam int unsigned KW = kse_pkg::KEY_FIELD_W;
	// generous: every key with a long sender gap, plus every
	// result under a long receiver stall, plus the mode-change pauses
	localparam int unsigned CYCLE_LIMIT = 200000;
	// quiet time before a mode write once the last sorted key has landed
	localparam int unsigned SETTLE_CYCLES = 8;
	// quiet time at the end, sized for a full list in signed mode
	localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 8;

	// compare_mode register values
	localparam logic MODE_UNSIGNED = 1'b0;
	localparam logic MODE_SIGNED = 1'b1;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;
	logic in_valid;
	logic in_stall;
	logic [KW-1:0] key_value;
	logic is_last;
	logic out_valid;
	logic out_stall;
	logic [KW-1:0] sorted_key;
	logic end_of_list;
	logic overflowed;

	// one sorted key as it should leave the output channel
	typedef struct packed {
		logic [KW-1:0] key;
		logic eol;
		logic ovf;
	} sorted_result_t;

	// directed stimulus row; typed rows carry the expected singleton result
	typedef struct packed {
		logic mode;
		logic [KW-1:0] key;
		logic last;
		logic typed;
		logic [KW-1:0] exp_key;
		logic exp_ovf;
	} probe_row_t;

	localparam probe_row_t DIRECTED [19] = '{
		// unsigned: singleton lists at both key extremes
		'{MODE_UNSIGNED, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
		'{MODE_UNSIGNED, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
		// unsigned: sign-boundary keys, order differs from signed mode
		'{MODE_UNSIGNED, 32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
		'{MODE_UNSIGNED, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
		'{MODE_UNSIGNED, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
		'{MODE_UNSIGNED, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
		'{MODE_UNSIGNED, 32'h0000_0001, 1'b1, 1'b0, 32'h0, 1'b0},
		// signed: most negative singleton, then the same boundary list
		'{MODE_SIGNED, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b0},
		'{MODE_SIGNED, 32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
		'{MODE_SIGNED, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
		'{MODE_SIGNED, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
		'{MODE_SIGNED, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
		'{MODE_SIGNED, 32'h0000_0001, 1'b1, 1'b0, 32'h0, 1'b0},
		// signed: duplicate keys around a negative one
		'{MODE_SIGNED, 32'h0000_0005, 1'b0, 1'b0, 32'h0, 1'b0},
		'{MODE_SIGNED, 32'hFFFF_FFFB, 1'b0, 1'b0, 32'h0, 1'b0},
		'{MODE_SIGNED, 32'h0000_0005, 1'b1, 1'b0, 32'h0, 1'b0},
		'{MODE_SIGNED, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0},
		// back to unsigned: alternating bit patterns
		'{MODE_UNSIGNED, 32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0, 1'b0},
		'{MODE_UNSIGNED, 32'hA5A5_A5A5, 1'b1, 1'b0, 32'h0, 1'b0}
	};

	// predictor state: keys of the open list, drop flag, current compare mode
	logic [KW-1:0] held_keys [$];
	logic overflow_seen = 1'b0;
	logic sort_signed = MODE_UNSIGNED;
	// results of the most recent transfer, and all results still owed
	sorted_result_t fresh_results [$];
	sorted_result_t sorted_due [$];

	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	key_sort_engine_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.key_value(key_value),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sorted_key(sorted_key),
		.end_of_list(end_of_list),
		.overflowed(overflowed)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [KW-1:0] want,
			input logic [KW-1:0] got);
		$display("[%0t] mismatch: %s, expected %h, got %h", $time, what, want, got);
		error_count++;
	endtask

	// strict order of a after b under the current compare mode
	function automatic logic ranks_after(input logic [KW-1:0] a, input logic [KW-1:0] b);
		if (sort_signed == MODE_SIGNED)
			return $signed(a) > $signed(b);
		return a > b;
	endfunction

	// store one accepted key; on the last key, produce the whole sorted list
	function automatic void absorb_key(input logic [KW-1:0] key, input logic last);
		logic [KW-1:0] run [$];
		logic [KW-1:0] v;
		int j;
		fresh_results.delete();
		if (held_keys.size() < DEPTH)
			held_keys.push_back(key);
		else
			overflow_seen = 1'b1; // store full: key dropped, last key included
		if (!last)
			return;
		run = held_keys;
		for (int i = 1; i < run.size(); i++) begin
			v = run[i];
			j = i;
			while (j > 0 && ranks_after(run[j-1], v)) begin
				run[j] = run[j-1];
				j--;
			end
			run[j] = v;
		end
		for (int i = 0; i < run.size(); i++)
			fresh_results.push_back('{run[i], logic'(i == run.size() - 1), overflow_seen});
		held_keys.delete();
		overflow_seen = 1'b0;
	endfunction

	// sender gaps: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 15);
		if (r < 10)
			return 0;
		if (r < 14)
			return $urandom_range(1, 3);
		if (r < 15)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	// keys biased toward extremes, sign boundary and duplicates
	function automatic logic [KW-1:0] random_key();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 7);
			5: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// all tasks below start and end right after a rising edge
	task automatic drive_key(input logic [KW-1:0] key, input logic last);
		in_valid <= 1'b1;
		key_value <= key;
		is_last <= last;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic hold_off(input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// one transfer through the predictor and into the owed results
	task automatic send_and_predict(input logic [KW-1:0] key, input logic last);
		drive_key(key, last);
		absorb_key(key, last);
		foreach (fresh_results[i])
			sorted_due.push_back(fresh_results[i]);
	endtask

	// wait until every owed result has landed and the engine has gone quiet
	task automatic quiesce();
		in_valid <= 1'b0;
		while (sorted_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic mode);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sort_signed = mode;
	endtask

	// receiver: stretches of free flow, short stalls and occasional long ones
	initial begin
		int r;
		int len;
		out_stall = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 9);
			if (r < 5) begin
				out_stall <= 1'b0;
				len = $urandom_range(1, 20);
			end else if (r < 8) begin
				out_stall <= 1'b1;
				len = $urandom_range(1, 3);
			end else if (r < 9) begin
				out_stall <= 1'b1;
				len = $urandom_range(5, 30);
			end else begin
				out_stall <= 1'b0;
				len = $urandom_range(40, 100);
			end
			repeat (len) @(posedge clk);
		end
	end

	// output check: every accepted transfer against the oldest owed result
	always @(posedge clk) begin
		sorted_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (sorted_due.size() == 0) begin
				report_mismatch("result with nothing owed", '0, sorted_key);
			end else begin
				want = sorted_due.pop_front();
				if (sorted_key !== want.key)
					report_mismatch("sorted_key", want.key, sorted_key);
				if (end_of_list !== want.eol)
					report_mismatch("end_of_list", KW'(want.eol), KW'(end_of_list));
				if (overflowed !== want.ovf)
					report_mismatch("overflowed", KW'(want.ovf), KW'(overflowed));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("key_sort_engine_unit_tb failed");
			$finish;
		end
	end

	initial begin
		probe_row_t row;
		logic list_open;
		logic steady;
		int lists;
		int rand_items;
		int len;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		in_valid = 1'b0;
		key_value = '0;
		is_last = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; the mode is only rewritten between lists
		list_open = 1'b0;
		for (int i = 0; i < $size(DIRECTED); i++) begin
			row = DIRECTED[i];
			if (!list_open && (i == 0 || row.mode != sort_signed)) begin
				quiesce();
				write_mode(row.mode);
			end
			drive_key(row.key, row.last);
			absorb_key(row.key, row.last);
			if (row.typed)
				sorted_due.push_back('{row.exp_key, 1'b1, row.exp_ovf});
			else
				foreach (fresh_results[k])
					sorted_due.push_back(fresh_results[k]);
			list_open = !row.last;
			hold_off(pick_gap());
		end

		// random lists: mostly short, plus one that fills the store and overflows
		// (its last key is the one dropped, so at least one key is lost)
		lists = 0;
		rand_items = 0;
		while (rand_items < 80 || lists < 5) begin
			if ($urandom_range(0, 1)) begin
				quiesce(); // doubles as the drain-to-empty pause for the sender
				write_mode(1'($urandom_range(0, 1)));
			end
			case (lists)
				1: len = DEPTH + $urandom_range(1, 3);
				default: len = $urandom_range(1, 10);
			endcase
			steady = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < len; k++) begin
				send_and_predict(random_key(), logic'(k == len - 1));
				rand_items++;
				hold_off(steady ? 0 : pick_gap());
			end
			lists++;
		end

		in_valid <= 1'b0;
		while (sorted_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("key_sort_engine_unit_tb passed");
		else
			$display("key_sort_engine_unit_tb failed");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/kse_pkg.sv
rtl/kse_cell.sv
rtl/key_sort_engine_unit.sv
sim/key_sort_engine_unit_tb.sv
